// File: sv/shortest_path_matrix_unit_defines.svh
// Assertion macros shared by the shortest path matrix unit RTL.
// Depends on nothing; the asserting modules name their clock clk_i and reset rst_ni.
`ifndef SHORTEST_PATH_MATRIX_UNIT_DEFINES_SVH
`define SHORTEST_PATH_MATRIX_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SPM_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define SPM_ASSERT(lbl, prop, msg)
`define SPM_NEVER(lbl, expr, msg)
`endif
`endif

// File: sv/spm_pkg.sv
// Shared types, constants and helpers of the shortest path matrix unit.
// Used by the controller, the datapath, the edge memory and the top level.
`default_nettype none
package spm_pkg;

  localparam int unsigned MAX_NODES = 16;
  localparam int unsigned NODE_W    = 4;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned DIST_W    = 24;
  localparam int unsigned PRED_W    = 5;
  localparam int unsigned ADDR_W    = 2 * NODE_W;

  localparam logic [DIST_W-1:0]  DIST_INF   = {DIST_W{1'b1}};
  localparam logic [PRED_W-1:0]  NO_PRED    = 5'h10;
  localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 5'd16;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_RUN   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_RELAX,
    ST_DRAIN,
    ST_PICK,
    ST_EMPTY,
    ST_EMIT
  } spm_state_e;

  typedef struct packed {
    logic              wr_edge;
    logic              capture;
    logic              init;
    logic              issue;
    logic [NODE_W-1:0] idx;
    logic              settle;
    logic              walk_init;
    logic              emit;
    logic              emit_empty;
  } spm_cmd_t;

  typedef struct packed {
    logic range_ok;
    logic best_vld;
    logic walk_last;
    logic out_free;
  } spm_stat_t;

  // Zero counts as one node and anything above the matrix size as the full matrix.
  function automatic logic [COUNT_W-1:0] nodes_in_use(input logic [COUNT_W-1:0] nc);
    logic [COUNT_W-1:0] n;
    n = nc;
    if (nc == '0) begin
      n = COUNT_W'(1);
    end else if (nc > COUNT_W'(MAX_NODES)) begin
      n = COUNT_W'(MAX_NODES);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// File: sv/spm_edge_mem.sv
// Edge weight matrix: one write port, one registered read port, row-major address.
// Per-entry valid bits make unwritten entries read as zero (no edge) after reset.
`default_nettype none
module spm_edge_mem
  import spm_pkg::*;
#(
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   wr_en_i,
  input  wire logic [ADDR_W-1:0]      wr_addr_i,
  input  wire logic [WEIGHT_BITS-1:0] wr_data_i,
  input  wire logic                   rd_en_i,
  input  wire logic [ADDR_W-1:0]      rd_addr_i,
  output logic      [WEIGHT_BITS-1:0] rd_data_o
);

  localparam int unsigned DEPTH = MAX_NODES * MAX_NODES;

  logic [WEIGHT_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]       vld_q;
  logic [WEIGHT_BITS-1:0] rd_data_q;
  logic                   rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule
`default_nettype wire

// File: sv/spm_ctrl.sv
// Sequencer of the shortest path matrix unit: accepts beats, steps relax passes,
// picks the next node and walks the path out. Uses spm_pkg and the assertion macros.
`default_nettype none
`include "shortest_path_matrix_unit_defines.svh"
module spm_ctrl
  import spm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               func_i,
  input  wire logic [COUNT_W-1:0] node_count_i,
  input  wire spm_stat_t          stat_i,
  output spm_cmd_t                cmd_o
);

  spm_state_e          state_q, state_d;
  logic [NODE_W-1:0]   idx_q, idx_d;
  logic [COUNT_W-1:0]  n_in_use;
  logic [COUNT_W-1:0]  last_idx;

  assign n_in_use = nodes_in_use(node_count_i);
  assign last_idx = n_in_use - COUNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cmd_o      = '0;
    cmd_o.idx  = idx_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (func_i == FUNC_WRITE) begin
            cmd_o.wr_edge = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
            state_d       = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        if (stat_i.range_ok) begin
          cmd_o.init = 1'b1;
          idx_d      = '0;
          state_d    = ST_RELAX;
        end else begin
          state_d = ST_EMPTY;
        end
      end
      ST_RELAX: begin
        cmd_o.issue = 1'b1;
        if (COUNT_W'(idx_q) == last_idx) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        // The last neighbor of the pass is compared in this cycle.
        state_d = ST_PICK;
      end
      ST_PICK: begin
        if (stat_i.best_vld) begin
          cmd_o.settle = 1'b1;
          idx_d        = '0;
          state_d      = ST_RELAX;
        end else begin
          cmd_o.walk_init = 1'b1;
          state_d         = ST_EMIT;
        end
      end
      ST_EMPTY: begin
        if (stat_i.out_free) begin
          cmd_o.emit_empty = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.walk_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `SPM_NEVER(a_idx_in_range, cmd_o.issue && (COUNT_W'(cmd_o.idx) >= n_in_use), "relax index beyond node count")

endmodule
`default_nettype wire

// File: sv/spm_datapath.sv
// Datapath of the shortest path matrix unit: distance, predecessor and settled
// tables, the relax and minimum stage, the path walk and the output register.
// Uses spm_pkg, spm_edge_mem and the assertion macros.
`default_nettype none
`include "shortest_path_matrix_unit_defines.svh"
module spm_datapath
  import spm_pkg::*;
#(
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire spm_cmd_t           cmd_i,
  output spm_stat_t               stat_o,
  input  wire logic [COUNT_W-1:0] node_count_i,
  input  wire logic [NODE_W-1:0]  edge_from_i,
  input  wire logic [NODE_W-1:0]  edge_to_i,
  input  wire logic [15:0]        edge_weight_i,
  input  wire logic [NODE_W-1:0]  start_node_i,
  input  wire logic [NODE_W-1:0]  end_node_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [NODE_W-1:0]  path_node_o,
  output logic                    found_o,
  output logic                    last_o
);

  localparam int unsigned SUM_W = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

  logic [DIST_W-1:0]      dist_q    [MAX_NODES];
  logic [PRED_W-1:0]      pred_q    [MAX_NODES];
  logic [MAX_NODES-1:0]   settled_q;

  logic [NODE_W-1:0]      start_q, end_q;
  logic [NODE_W-1:0]      cur_q;
  logic [DIST_W-1:0]      cur_dist_q;
  logic [NODE_W-1:0]      best_q;
  logic                   best_vld_q;
  logic [DIST_W-1:0]      low_q;
  logic                   relax_vld_q;
  logic [NODE_W-1:0]      ridx_q;
  logic [NODE_W-1:0]      walk_q;
  logic                   first_q;

  logic                   out_valid_q;
  logic [NODE_W-1:0]      path_node_q;
  logic                   found_q;
  logic                   last_q;

  logic [COUNT_W-1:0]     n_in_use;
  logic [31:0]            wt_wide;
  logic [WEIGHT_BITS-1:0] wr_data;
  logic [WEIGHT_BITS-1:0] w;
  logic [SUM_W-1:0]       sum;
  logic [DIST_W-1:0]      sat;
  logic [DIST_W-1:0]      d_i;
  logic [DIST_W-1:0]      new_d;
  logic                   upd;
  logic                   cand;
  logic                   walk_last;
  logic                   pass_start;
  logic                   out_load;

  assign n_in_use = nodes_in_use(node_count_i);
  assign wt_wide  = 32'(edge_weight_i);
  assign wr_data  = wt_wide[WEIGHT_BITS-1:0];

  spm_edge_mem #(
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_edge_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (cmd_i.wr_edge),
    .wr_addr_i({edge_from_i, edge_to_i}),
    .wr_data_i(wr_data),
    .rd_en_i  (cmd_i.issue),
    .rd_addr_i({cur_q, cmd_i.idx}),
    .rd_data_o(w)
  );

  // Relax one neighbor of the current node and fold it into the running minimum.
  assign d_i   = dist_q[ridx_q];
  assign sum   = SUM_W'(cur_dist_q) + SUM_W'(w);
  assign sat   = (sum > SUM_W'(DIST_INF)) ? DIST_INF : sum[DIST_W-1:0];
  assign upd   = relax_vld_q && !settled_q[ridx_q] && (w != '0) && (sat < d_i);
  assign new_d = upd ? sat : d_i;
  assign cand  = relax_vld_q && !settled_q[ridx_q] && (new_d < low_q);

  assign pass_start = cmd_i.issue && (cmd_i.idx == '0);
  assign walk_last  = (pred_q[walk_q] == NO_PRED);
  assign out_load   = cmd_i.emit || cmd_i.emit_empty;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      start_q <= start_node_i;
      end_q   <= end_node_i;
    end
    if (cmd_i.init) begin
      // The start node begins settled at distance zero; every other node is unreached.
      for (int k = 0; k < MAX_NODES; k++) begin
        dist_q[k]    <= (NODE_W'(k) == start_q) ? {DIST_W{1'b0}} : DIST_INF;
        pred_q[k]    <= NO_PRED;
        settled_q[k] <= (NODE_W'(k) == start_q);
      end
      cur_q           <= start_q;
      cur_dist_q      <= '0;
    end else if (cmd_i.settle) begin
      settled_q[best_q] <= 1'b1;
      cur_q             <= best_q;
      cur_dist_q        <= low_q;
    end
    if (upd) begin
      dist_q[ridx_q] <= sat;
      pred_q[ridx_q] <= PRED_W'(cur_q);
    end
    ridx_q <= cmd_i.idx;
    if (pass_start) begin
      low_q <= DIST_INF;
    end else if (cand) begin
      low_q  <= new_d;
      best_q <= ridx_q;
    end
    if (cmd_i.walk_init) begin
      walk_q <= end_q;
    end else if (cmd_i.emit) begin
      walk_q <= pred_q[walk_q][NODE_W-1:0];
    end
    if (cmd_i.emit) begin
      if (first_q && walk_last) begin
        path_node_q <= '0;
        found_q     <= 1'b0;
        last_q      <= 1'b1;
      end else begin
        path_node_q <= walk_q;
        found_q     <= 1'b1;
        last_q      <= walk_last;
      end
    end else if (cmd_i.emit_empty) begin
      path_node_q <= '0;
      found_q     <= 1'b0;
      last_q      <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relax_vld_q <= 1'b0;
      best_vld_q  <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      relax_vld_q <= cmd_i.issue;
      if (pass_start) begin
        best_vld_q <= 1'b0;
      end else if (cand) begin
        best_vld_q <= 1'b1;
      end
      if (cmd_i.walk_init) begin
        first_q <= 1'b1;
      end else if (cmd_i.emit) begin
        first_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.range_ok  = (COUNT_W'(start_q) < n_in_use) && (COUNT_W'(end_q) < n_in_use);
  assign stat_o.best_vld  = best_vld_q;
  assign stat_o.walk_last = walk_last;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign path_node_o = path_node_q;
  assign found_o     = found_q;
  assign last_o      = last_q;

  `SPM_ASSERT(a_settle_unsettled, cmd_i.settle |-> (best_vld_q && !settled_q[best_q]), "settling a node that is already settled")
  `SPM_NEVER(a_settle_in_flight, cmd_i.settle && relax_vld_q, "node settled while a relax is in flight")
  `SPM_ASSERT(a_path_ends_at_start, (cmd_i.emit && walk_last && !first_q) |=> (path_node_q == $past(start_q)), "path does not end at the start node")

endmodule
`default_nettype wire

// File: sv/shortest_path_matrix_unit.sv
// Top level of the shortest path matrix unit: node count register, controller and datapath.
// Depends on spm_pkg, spm_ctrl, spm_datapath and spm_edge_mem.
//
//   Channel | Direction | Handshake                 | Payload
//   --------+-----------+---------------------------+------------------------------------
//   in      | input     | in_valid_i / in_ready_o   | func, edge_from/to/weight, start/end
//   out     | output    | out_valid_o / out_ready_i | path_node, found, last
//   cfg     | input     | cfg_valid_i / cfg_ready_o | node_count
//
// An edge write goes straight to the edge memory. A run starts with a capture and an init
// step, then every settled node takes one edge memory read per neighbor, a drain and a pick,
// and the path is then walked out beat by beat as the output register frees up.
// Reset clears the edge matrix through per-entry valid bits and sets node_count to 16.
// Stalled beats hold in the output register; new input waits until the last beat is loaded.
`default_nettype none
module shortest_path_matrix_unit
  import spm_pkg::*;
#(
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [COUNT_W-1:0] cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               func_i,
  input  wire logic [NODE_W-1:0]  edge_from_i,
  input  wire logic [NODE_W-1:0]  edge_to_i,
  input  wire logic [15:0]        edge_weight_i,
  input  wire logic [NODE_W-1:0]  start_node_i,
  input  wire logic [NODE_W-1:0]  end_node_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [NODE_W-1:0]  path_node_o,
  output logic                    found_o,
  output logic                    last_o
);

  logic [COUNT_W-1:0] node_count_q;
  spm_cmd_t           cmd;
  spm_stat_t          stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RESET;
    end else if (cfg_valid_i) begin
      node_count_q <= cfg_data_i;
    end
  end

  spm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .node_count_i(node_count_q),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  spm_datapath #(
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .node_count_i (node_count_q),
    .edge_from_i  (edge_from_i),
    .edge_to_i    (edge_to_i),
    .edge_weight_i(edge_weight_i),
    .start_node_i (start_node_i),
    .end_node_i   (end_node_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .path_node_o  (path_node_o),
    .found_o      (found_o),
    .last_o       (last_o)
  );

endmodule
`default_nettype wire
